>>> design/lfc_pkg.sv
// shared types, constants and the quarter-wave cosine rom contents
// for the linear fm chirp generator; no dependencies
package lfc_pkg;

   // fixed widths of the datapath
   localparam int PHASE_BITS      = 32;
   localparam int SAMPLE_BITS     = 16;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int COUNT_BITS      = 16;

   localparam int AMP_BITS    = 15;
   localparam int COS_BITS    = 15;
   localparam int PROD_BITS   = AMP_BITS + COS_BITS;
   localparam int ROUND_SHIFT = 31 - SAMPLE_BITS;
   localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
   localparam int TABLE_N     = 1 << TABLE_ADDR_BITS;
   localparam int TABLE_SIZE  = TABLE_N + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // result queue in the back end
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_STEP   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHIRP_STEP   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_OFFSET = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_LENGTH = 3'd4;

   // register reset values
   localparam logic [14:0] AMPLITUDE_RESET    = 15'd16384;
   localparam logic [15:0] SWEEP_LENGTH_RESET = 16'd1024;

   typedef struct packed {
      logic [14:0]        amplitude;
      logic [31:0]        start_step;
      logic signed [31:0] chirp_step;
      logic [31:0]        phase_offset;
      logic [15:0]        sweep_length;
   } cfg_type;

   // one item of work from front to back
   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [COUNT_BITS-1:0] index;
      logic                  last;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef logic [COS_BITS-1:0] cos_rom_type [0:TABLE_SIZE-1];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // cos(x) for x in q30 radians by a truncating taylor series,
   // scaled to the 32767 range
   function automatic logic [COS_BITS-1:0] cos_q15(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        scaled;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd462; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd552; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      scaled = ($unsigned(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      return scaled[COS_BITS-1:0];
   endfunction

   // quarter-wave table, worked out at elaboration
   function automatic cos_rom_type build_cos_table();
      cos_rom_type t;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         t[k] = cos_q15((HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS);
      end
      return t;
   endfunction

   localparam cos_rom_type COS_TABLE = build_cos_table();

endpackage

>>> design/linear_fm_chirp_generator.sv
// top level of the linear fm chirp generator: configuration registers,
// front end, work queue and back end; depends on lfc_pkg and the lfc_ modules
//
// Usage:
//   Input side is a queue: drive req_restart and raise push while full is low;
//   each accepted item is one sample tick (restart high starts a new sweep).
//   Result side is a queue: while empty is low the oldest sample is on
//   rsp_sample_value, rsp_sample_index and rsp_last; pop takes it.
//   Configuration: csr_write with csr_index and csr_data writes one register
//   (amplitude, start_step, chirp_step, phase_offset, sweep_length); write
//   only while the block is idle. Unknown indexes are ignored.
// Timing:
//   Each accepted tick is queued, then runs the back-end stages. Throughput
//   is one sample per cycle while full is low, set by the phase and step
//   accumulators in the front end, which update once per accepted item.
//   The back end runs offset add, rom read, multiply and rounding as stages.
// Reset and stall:
//   Synchronous reset clears the accumulators, the sweep counter and both
//   queues and loads the register reset values; the cosine rom is constant,
//   so no fill pass is needed. When the receiver stops popping, the result
//   queue fills, the back end stops taking work, and full rises at the input.
module linear_fm_chirp_generator (
   input  logic        clock,
   input  logic        reset,
   // tick items
   input  logic        push,
   output logic        full,
   input  logic        req_restart,
   // sample results
   output logic        empty,
   input  logic        pop,
   output logic signed [lfc_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   output logic [lfc_pkg::COUNT_BITS-1:0]         rsp_sample_index,
   output logic        rsp_last,
   // configuration
   input  logic        csr_write,
   input  logic [lfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import lfc_pkg::*;

   cfg_type          cfg_ff;
   work_type         front_item, q_item;
   queue_status_type q_status;
   logic             accept;
   logic             q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude    <= AMPLITUDE_RESET;
         cfg_ff.start_step   <= '0;
         cfg_ff.chirp_step   <= '0;
         cfg_ff.phase_offset <= '0;
         cfg_ff.sweep_length <= SWEEP_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AMPLITUDE:    cfg_ff.amplitude    <= csr_data[14:0];
            CSR_START_STEP:   cfg_ff.start_step   <= csr_data;
            CSR_CHIRP_STEP:   cfg_ff.chirp_step   <= $signed(csr_data);
            CSR_PHASE_OFFSET: cfg_ff.phase_offset <= csr_data;
            CSR_SWEEP_LENGTH: cfg_ff.sweep_length <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   lfc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .restart (req_restart),
      .work    (front_item)
   );

   lfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .status    (q_status)
   );

   lfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_sample_value (rsp_sample_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last         (rsp_last)
   );

   // back end never takes work from an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("work taken from empty queue");

   // an item pushed into an empty queue is there the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (accept && q_status.empty) |=> !q_status.empty)
      else $error("pushed item lost");

   // every delivered sample has a position from one
   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_sample_index != '0))
      else $error("sample index zero");

   // reset leaves the input side open and the result side empty
   a_full_after_reset: assert property (@(posedge clock)
      reset |=> !full && empty)
      else $error("queues not cleared by reset");

endmodule

>>> design/lfc_front.sv
// front end: takes tick items, runs the sweep counter and the
// quadratic phase accumulators; depends on lfc_pkg
module lfc_front (
   input  logic              clock,
   input  logic              reset,
   input  lfc_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic              restart,
   output lfc_pkg::work_type work
);
   import lfc_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] len;
   logic [PHASE_BITS-1:0] chirp;
   logic [PHASE_BITS-1:0] first_step;
   logic                  fresh;

   // effective sweep length, zero counts as one
   assign len = (cfg.sweep_length == 16'd0) ? COUNT_BITS'(1) : COUNT_BITS'(cfg.sweep_length);

   assign chirp      = PHASE_BITS'(cfg.chirp_step);
   assign first_step = PHASE_BITS'(cfg.start_step) + chirp;
   assign fresh      = restart || (count_ff == '0) || (count_ff >= len);

   // next accumulator and counter values
   always_comb begin
      if (fresh) begin
         count_in = COUNT_BITS'(1);
         phase_in = first_step;
         step_in  = first_step + (chirp << 1);
      end else begin
         count_in = count_ff + COUNT_BITS'(1);
         phase_in = phase_ff + step_ff;
         step_in  = step_ff + (chirp << 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   // item handed to the queue
   assign work.phase = phase_in;
   assign work.index = count_in;
   assign work.last  = (count_in == len);

endmodule

>>> design/lfc_queue.sv
// short queue of work items between front and back end
// depends on lfc_pkg
module lfc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lfc_pkg::work_type         push_item,
   input  logic                      pop,
   output lfc_pkg::work_type         pop_item,
   output lfc_pkg::queue_status_type status
);
   import lfc_pkg::*;

   work_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/lfc_back.sv
// back end: phase offset, cosine rom lookup, amplitude multiply, rounding
// and the result queue; depends on lfc_pkg
module lfc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lfc_pkg::cfg_type              cfg,
   input  lfc_pkg::queue_status_type     q_status,
   input  lfc_pkg::work_type             q_item,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic signed [lfc_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   output logic [lfc_pkg::COUNT_BITS-1:0]         rsp_sample_index,
   output logic                          rsp_last
);
   import lfc_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [COUNT_BITS-1:0]         index;
      logic                          last;
   } result_type;

   localparam logic [ROM_ADDR_BITS-1:0] ROM_TOP = ROM_ADDR_BITS'(TABLE_N);
   localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (ROUND_SHIFT - 1);

   // pipeline valid bits
   logic v1_ff, v2_ff, v3_ff;

   // stage payloads
   logic [ROM_ADDR_BITS-1:0] addr_ff;
   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [COUNT_BITS-1:0]    idx1_ff, idx2_ff, idx3_ff;
   logic                     last1_ff, last2_ff, last3_ff;
   logic [COS_BITS-1:0]      cos_ff;
   logic [PROD_BITS-1:0]     prod_ff;

   // result queue
   result_type             out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CNT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic [OUT_CNT_BITS:0]   occupancy;
   logic                    out_pop;

   logic [PHASE_BITS-1:0]      ph;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] k;
   logic [ROM_ADDR_BITS-1:0]   addr_in;
   logic [PROD_BITS:0]         rounded;
   logic [PROD_BITS:0]         mag;
   result_type                 result;

   // take a work item only when the result queue has room for everything in flight
   assign occupancy = (OUT_CNT_BITS + 1)'(out_cnt_ff) + (OUT_CNT_BITS + 1)'(v1_ff)
                    + (OUT_CNT_BITS + 1)'(v2_ff) + (OUT_CNT_BITS + 1)'(v3_ff);
   assign q_pop = !q_status.empty && (occupancy < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

   // stage 1: offset, quadrant and table address
   assign ph      = q_item.phase + PHASE_BITS'(cfg.phase_offset);
   assign quad    = ph[PHASE_BITS-1 -: 2];
   assign k       = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   assign addr_in = quad[0] ? (ROM_TOP - {1'b0, k}) : {1'b0, k};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      neg1_ff  <= quad[1] ^ quad[0];
      idx1_ff  <= q_item.index;
      last1_ff <= q_item.last;
      // stage 2: rom read
      cos_ff   <= COS_TABLE[addr_ff];
      neg2_ff  <= neg1_ff;
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
      // stage 3: amplitude multiply
      prod_ff  <= PROD_BITS'(cos_ff) * PROD_BITS'(cfg.amplitude);
      neg3_ff  <= neg2_ff;
      idx3_ff  <= idx2_ff;
      last3_ff <= last2_ff;
   end

   // stage 4: round half away from zero, then apply sign
   assign rounded = (PROD_BITS + 1)'(prod_ff) + ROUND_HALF;
   assign mag     = rounded >> ROUND_SHIFT;
   assign result.value = neg3_ff ? -$signed(SAMPLE_BITS'(mag)) : $signed(SAMPLE_BITS'(mag));
   assign result.index = idx3_ff;
   assign result.last  = last3_ff;

   // result queue
   assign empty   = (out_cnt_ff == '0);
   assign out_pop = pop && !empty;
   assign rsp_sample_value = out_mem_ff[out_rd_ff].value;
   assign rsp_sample_index = out_mem_ff[out_rd_ff].index;
   assign rsp_last         = out_mem_ff[out_rd_ff].last;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (v3_ff && !out_pop) begin
         out_cnt_in = out_cnt_ff + OUT_CNT_BITS'(1);
      end else if (out_pop && !v3_ff) begin
         out_cnt_in = out_cnt_ff - OUT_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (v3_ff) begin
            out_wr_ff <= out_wr_ff + OUT_PTR_BITS'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + OUT_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         out_mem_ff[out_wr_ff] <= result;
      end
   end

endmodule

>>> tb/sv/lfc_checker.sv
// sample checker for the linear fm chirp generator: watches the tick, sample
// and register ports, predicts every sample and compares; depends on lfc_pkg
`timescale 1ns / 1ps

module lfc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_restart,
   input  logic        empty,
   input  logic        pop,
   input  logic signed [lfc_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic [lfc_pkg::COUNT_BITS-1:0]         rsp_sample_index,
   input  logic        rsp_last,
   input  logic        csr_write,
   input  logic [lfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data,
   output int          errors,
   output int          due_count,
   output int          ticks_seen,
   output int          samples_checked
);
   import lfc_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [COUNT_BITS-1:0]         index;
      logic                          last;
   } chirp_sample_type;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // quarter-wave cosine, unsigned q0.15
   logic [COS_BITS-1:0] quarter_cos [0:TABLE_N];

   // register copies
   logic [14:0] amp;
   logic [31:0] start_step;
   logic [31:0] chirp_step;
   logic [31:0] phase_offset;
   logic [15:0] sweep_length;

   // sweep state
   logic [PHASE_BITS-1:0] phase_acc;
   logic [PHASE_BITS-1:0] step_acc;
   logic [COUNT_BITS-1:0] sweep_count;

   chirp_sample_type samples_due [$];

   // truncating taylor series in q30, rounded to the 32767 scale
   function automatic logic [COS_BITS-1:0] taylor_cos(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic [63:0]        rounded;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      acc  = $signed(Q30_ONE);
      for (int n = 1; n <= 12; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > $signed(Q30_ONE)) begin
         acc = $signed(Q30_ONE);
      end
      rounded = ($unsigned(acc) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      return rounded[COS_BITS-1:0];
   endfunction

   initial begin
      for (int k = 0; k <= TABLE_N; k++) begin
         quarter_cos[k] = taylor_cos((HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS);
      end
   end

   // advance the sweep by one tick and work out the sample it yields
   function automatic chirp_sample_type next_chirp_sample(input logic restart);
      logic [15:0]           len;
      logic [PHASE_BITS-1:0] ph;
      logic [1:0]            quad;
      logic [TABLE_ADDR_BITS-1:0] k;
      int                    c;
      logic                  neg;
      logic [31:0]           mag;
      chirp_sample_type      s;
      len = (sweep_length == 16'd0) ? 16'd1 : sweep_length;
      // new sweep on restart, at power up and after the last sample
      if (restart || sweep_count == '0 || sweep_count >= len) begin
         phase_acc   = '0;
         step_acc    = start_step + chirp_step;
         sweep_count = '0;
      end
      sweep_count = sweep_count + 1'b1;
      phase_acc   = phase_acc + step_acc;
      step_acc    = step_acc + {chirp_step[30:0], 1'b0};
      // quadrant folding into the quarter table
      ph   = phase_acc + phase_offset;
      quad = ph[PHASE_BITS-1 -: 2];
      k    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      case (quad)
         2'd0:    c = int'(quarter_cos[k]);
         2'd1:    c = -int'(quarter_cos[TABLE_N - int'(k)]);
         2'd2:    c = -int'(quarter_cos[k]);
         default: c = int'(quarter_cos[TABLE_N - int'(k)]);
      endcase
      // scale, round half away from zero, restore sign
      neg = (c < 0);
      mag = 32'(neg ? -c : c) * 32'(amp);
      mag = (mag + (32'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      s.value = neg ? SAMPLE_BITS'(32'd0 - mag) : SAMPLE_BITS'(mag);
      s.index = sweep_count;
      s.last  = (sweep_count == len);
      return s;
   endfunction

   always @(posedge clock) begin : watch
      chirp_sample_type want;
      chirp_sample_type fresh_sample;
      if (reset) begin
         amp          = AMPLITUDE_RESET;
         start_step   = '0;
         chirp_step   = '0;
         phase_offset = '0;
         sweep_length = SWEEP_LENGTH_RESET;
         phase_acc    = '0;
         step_acc     = '0;
         sweep_count  = '0;
         samples_due.delete();
      end else begin
         // register writes; spare indexes change nothing
         if (csr_write) begin
            case (csr_index)
               CSR_AMPLITUDE:    amp          = csr_data[14:0];
               CSR_START_STEP:   start_step   = csr_data;
               CSR_CHIRP_STEP:   chirp_step   = csr_data;
               CSR_PHASE_OFFSET: phase_offset = csr_data;
               CSR_SWEEP_LENGTH: sweep_length = csr_data[15:0];
               default: ;
            endcase
         end
         // sample leaving the block
         if (pop && !empty) begin
            if (samples_due.size() == 0) begin
               errors++;
               $display("%0t: sample with nothing due: value %0d index %0d last %0b",
                        $time, rsp_sample_value, rsp_sample_index, rsp_last);
            end else begin
               want = samples_due.pop_front();
               samples_checked++;
               if (rsp_sample_value !== want.value) begin
                  errors++;
                  $display("%0t: sample_value expected %0d actual %0d",
                           $time, want.value, rsp_sample_value);
               end
               if (rsp_sample_index !== want.index) begin
                  errors++;
                  $display("%0t: sample_index expected %0d actual %0d",
                           $time, want.index, rsp_sample_index);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
         // tick entering the block
         if (push && !full) begin
            fresh_sample = next_chirp_sample(req_restart);
            samples_due  = {samples_due, fresh_sample};
            ticks_seen++;
         end
      end
      due_count <= samples_due.size();
   end

endmodule

>>> tb/sv/tb.sv
// top of the chirp generator testbench: clock, reset, tick and register
// stimulus, sample popping and the verdict; depends on lfc_pkg, lfc_checker
`timescale 1ns / 1ps

module tb;
   import lfc_pkg::*;

   localparam int LIMIT_CYCLES = 100000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 100;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_restart = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_value;
   logic [COUNT_BITS-1:0]         rsp_sample_index;
   logic rsp_last;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   int errors;
   int due_count;
   int ticks_seen;
   int samples_checked;
   int cycles = 0;
   int settings = 1;
   bit steady = 1'b0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;

   linear_fm_chirp_generator dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_restart(req_restart),
      .empty(empty), .pop(pop),
      .rsp_sample_value(rsp_sample_value), .rsp_sample_index(rsp_sample_index),
      .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   lfc_checker checker_i (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_restart(req_restart),
      .empty(empty), .pop(pop),
      .rsp_sample_value(rsp_sample_value), .rsp_sample_index(rsp_sample_index),
      .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .due_count(due_count), .ticks_seen(ticks_seen),
      .samples_checked(samples_checked)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // sample receiver: random stalls, occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else if (hold_seen != hold_ask) begin
         hold_seen++;
         hold_left = HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= steady || ($urandom_range(99) >= 18);
      end
   end

   // one register write, with csr_write low before it
   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // one tick item, returns at the edge that takes it
   task automatic send_tick(input logic restart);
      if (!steady && $urandom_range(99) < 15) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      push        <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (full);
   endtask

   // stop sending and wait until every sample is out; the first edge lets
   // the count catch up with an item taken at the current edge
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random register setting, extremes included
   task automatic random_setting();
      logic [31:0] data;
      data = $urandom;
      case ($urandom_range(3))
         0:       data[14:0] = 15'd0;
         1:       data[14:0] = 15'h7fff;
         default: ;
      endcase
      csr_put(CSR_AMPLITUDE, data);
      csr_put(CSR_START_STEP, ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom);
      data = $urandom;
      if ($urandom_range(1) == 0) begin
         data = 32'($urandom_range(40000)) - 32'd20000;
      end
      csr_put(CSR_CHIRP_STEP, data);
      csr_put(CSR_PHASE_OFFSET, $urandom);
      data = $urandom;
      case ($urandom_range(9))
         0:       data[15:0] = 16'd0;
         1:       data[15:0] = 16'hffff;
         2:       data[15:0] = 16'd1;
         default: data[15:0] = 16'($urandom_range(2, 40));
      endcase
      csr_put(CSR_SWEEP_LENGTH, data);
      if ($urandom_range(2) == 0) begin
         csr_put(CSR_INDEX_BITS'(CSR_SPARE_LO + $urandom_range(2)), $urandom);
      end
      settings++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: flat cosine at phase zero
      repeat (3) send_tick(1'b0);

      // config change in the middle of a sweep
      wait_idle();
      csr_put(CSR_START_STEP, 32'h0100_0000);
      csr_put(CSR_CHIRP_STEP, 32'h0001_0000);
      csr_put(CSR_AMPLITUDE, 32'h0000_7fff);
      csr_put(CSR_PHASE_OFFSET, 32'h4000_0000);
      settings++;
      repeat (3) send_tick(1'b0);

      // short sweeps, restart mid-sweep and restart with the end of a sweep
      wait_idle();
      csr_put(CSR_SWEEP_LENGTH, 32'd3);
      settings++;
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);

      // zero length and zero amplitude, then spare indexes and extremes
      wait_idle();
      csr_put(CSR_SWEEP_LENGTH, 32'd0);
      csr_put(CSR_AMPLITUDE, 32'd0);
      settings++;
      repeat (2) send_tick(1'b0);
      wait_idle();
      csr_put(CSR_SPARE_LO, 32'hffff_ffff);
      csr_put(CSR_INDEX_BITS'(CSR_SPARE_LO + 2), 32'h5a5a_a5a5);
      csr_put(CSR_AMPLITUDE, 32'd1);
      csr_put(CSR_START_STEP, 32'hffff_ffff);
      csr_put(CSR_CHIRP_STEP, 32'h8000_0000);
      csr_put(CSR_PHASE_OFFSET, 32'hffff_ffff);
      settings++;
      repeat (3) send_tick(1'b0);

      // longest sweep, largest positive chirp
      wait_idle();
      csr_put(CSR_SWEEP_LENGTH, 32'h0000_ffff);
      csr_put(CSR_CHIRP_STEP, 32'h7fff_ffff);
      csr_put(CSR_AMPLITUDE, 32'h0000_7fff);
      settings++;
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);

      // random phases, each with a fresh register setting
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         random_setting();
         steady = (p == 3);
         if (p == 5) begin
            steady = 1'b1;
            hold_ask++;
         end
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if (p == 5 && i == 60) begin
               steady = 1'b0;
            end
            if (p == 6 && i == PHASE_TICKS / 2) begin
               wait_idle();
            end
            send_tick($urandom_range(99) < 6);
         end
      end
      steady = 1'b0;

      wait_idle();
      $display("tb: %0d ticks sent, %0d samples compared over %0d register settings",
               ticks_seen, samples_checked, settings);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/lfc_pkg.sv
design/lfc_front.sv
design/lfc_queue.sv
design/lfc_back.sv
design/linear_fm_chirp_generator.sv
tb/sv/lfc_checker.sv
tb/sv/tb.sv
